// File: src/ibd_pkg.sv
// shared types, constants and reciprocal table for the image block downscaler
// no dependencies
`default_nettype none
package ibd_pkg;

    localparam int MAX_FACTOR = 16;
    localparam int LANE_W     = 16;
    localparam int RECIP_W    = 23;
    localparam int RECIP_SH   = 24;
    localparam int PROD_W     = LANE_W + RECIP_W;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_FACTOR = 3'd2;
    localparam logic [2:0] REG_COLOUR = 3'd3;

    // 3x3 weights, row major
    localparam logic [2:0] WEIGHTS3 [9] = '{3'd1, 3'd2, 3'd1, 3'd2, 3'd4, 3'd2,
                                            3'd1, 3'd2, 3'd1};

    typedef logic [LANE_W-1:0] t_lane;

    typedef struct packed {
        logic               wr;
        logic               first;
        logic [2:0]         weight;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic               done;
        logic               last;
        logic [RECIP_W-1:0] recip;
    } t_acc_req;

    typedef struct packed {
        logic               done;
        logic               last;
        t_lane              s_red;
        t_lane              s_green;
        t_lane              s_blue;
        logic [RECIP_W-1:0] recip;
    } t_sum;

    // ceil(2^24 / divisor), divisor is f*f for even f and 16 for f = 3
    function automatic logic [RECIP_W-1:0] recip_of(input logic [4:0] f);
        logic [RECIP_W-1:0] m;
        case (f)
            5'd2:    m = 23'd4194304;
            5'd3:    m = 23'd1048576;
            5'd4:    m = 23'd1048576;
            5'd6:    m = 23'd466034;
            5'd8:    m = 23'd262144;
            5'd10:   m = 23'd167773;
            5'd12:   m = 23'd116509;
            5'd14:   m = 23'd85599;
            5'd16:   m = 23'd65536;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

// File: src/ibd_accum.sv
// tile sum line store with read-modify-write and forwarding
// depends on ibd_pkg
`default_nettype none
module ibd_accum #(
    parameter int ADDR_W = 11
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_adv,
    input  wire logic              i_req_vld,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire ibd_pkg::t_acc_req i_req,
    output ibd_pkg::t_sum          o_sum,
    output logic                   o_sum_vld
);
    localparam int DEPTH = 2 ** ADDR_W;

    logic [3*ibd_pkg::LANE_W-1:0] mem [DEPTH];
    logic [3*ibd_pkg::LANE_W-1:0] r_rdata;
    logic [3*ibd_pkg::LANE_W-1:0] r_fwd_data;
    logic [ADDR_W-1:0]            r_fwd_addr;
    logic                         r_fwd_vld;
    logic [ADDR_W-1:0]            r_addr;
    ibd_pkg::t_acc_req            r_s1;
    logic                         r_s1_vld;
    logic [3*ibd_pkg::LANE_W-1:0] base;
    logic [3*ibd_pkg::LANE_W-1:0] n_sum;

    always_comb begin
        if (r_s1.first) begin
            base = '0;
        end else if (r_fwd_vld && r_fwd_addr == r_addr) begin
            base = r_fwd_data;
        end else begin
            base = r_rdata;
        end
        n_sum[47:32] = base[47:32]
                       + ibd_pkg::LANE_W'(r_s1.weight) * ibd_pkg::LANE_W'(r_s1.red);
        n_sum[31:16] = base[31:16]
                       + ibd_pkg::LANE_W'(r_s1.weight) * ibd_pkg::LANE_W'(r_s1.green);
        n_sum[15:0]  = base[15:0]
                       + ibd_pkg::LANE_W'(r_s1.weight) * ibd_pkg::LANE_W'(r_s1.blue);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rdata <= mem[i_addr];
            r_addr  <= i_addr;
            r_s1    <= i_req;
            if (r_s1_vld && r_s1.wr) begin
                mem[r_addr] <= n_sum;
            end
            r_fwd_data    <= n_sum;
            r_fwd_addr    <= r_addr;
            o_sum.done    <= r_s1.done;
            o_sum.last    <= r_s1.last;
            o_sum.s_red   <= n_sum[47:32];
            o_sum.s_green <= n_sum[31:16];
            o_sum.s_blue  <= n_sum[15:0];
            o_sum.recip   <= r_s1.recip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_fwd_vld <= 1'b0;
            o_sum_vld <= 1'b0;
        end else if (i_adv) begin
            r_s1_vld  <= i_req_vld;
            r_fwd_vld <= r_s1_vld && r_s1.wr;
            o_sum_vld <= r_s1_vld && r_s1.wr && r_s1.done;
        end
    end
endmodule
`default_nettype wire

// File: src/ibd_scale.sv
// reciprocal multiply of tile sums and output register
// depends on ibd_pkg
`default_nettype none
module ibd_scale (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_adv,
    input  wire logic          i_sum_vld,
    input  wire ibd_pkg::t_sum i_sum,
    output logic               o_out_valid,
    output logic [7:0]         o_out_red,
    output logic [7:0]         o_out_green,
    output logic [7:0]         o_out_blue,
    output logic               o_out_last
);
    logic [ibd_pkg::PROD_W-1:0] r_p_red;
    logic [ibd_pkg::PROD_W-1:0] r_p_green;
    logic [ibd_pkg::PROD_W-1:0] r_p_blue;
    logic                       r_p_last;
    logic                       r_p_vld;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_p_red     <= ibd_pkg::PROD_W'(i_sum.s_red)   * ibd_pkg::PROD_W'(i_sum.recip);
            r_p_green   <= ibd_pkg::PROD_W'(i_sum.s_green) * ibd_pkg::PROD_W'(i_sum.recip);
            r_p_blue    <= ibd_pkg::PROD_W'(i_sum.s_blue)  * ibd_pkg::PROD_W'(i_sum.recip);
            r_p_last    <= i_sum.last;
            o_out_red   <= r_p_red[ibd_pkg::RECIP_SH +: 8];
            o_out_green <= r_p_green[ibd_pkg::RECIP_SH +: 8];
            o_out_blue  <= r_p_blue[ibd_pkg::RECIP_SH +: 8];
            o_out_last  <= r_p_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld     <= 1'b0;
            o_out_valid <= 1'b0;
        end else if (i_adv) begin
            r_p_vld     <= i_sum_vld;
            o_out_valid <= r_p_vld;
        end
    end
endmodule
`default_nettype wire

// File: src/image_block_downscaler_core.sv
// top level of the image block downscaler: position counters, config registers
// depends on ibd_pkg, ibd_accum, ibd_scale
//
// channel  direction  handshake            payload
// in       input      i_in_valid/o_in_stall i_red, i_green, i_blue
// out      output     o_out_valid/i_out_stall o_out_red/green/blue, o_out_last
// cfg      input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// one pixel item per cycle unless stalled; a result passes r_s1, o_sum, r_p, o_out
// the line store takes one read and one write per cycle when not stalled, the pixel
// behind is forwarded from the previous write when it hits the same tile column
// the whole pipeline freezes while a result is held by the output stall
// reset clears counters and loads width min(MAX_WIDTH, 4096), height 4096, factor 2, colour mode
// the line store needs no clearing: a tile's first pixel overwrites its entry
`default_nettype none
module image_block_downscaler_core #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_red,
    input  wire logic [7:0]  i_green,
    input  wire logic [7:0]  i_blue,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_out_red,
    output logic [7:0]       o_out_green,
    output logic [7:0]       o_out_blue,
    output logic             o_out_last,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    localparam int ADDR_W  = $clog2(MAX_WIDTH / 2);
    localparam int W_W     = $clog2(MAX_WIDTH + 1);
    localparam int H_W     = 13;
    localparam int W_RESET = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;

    logic              adv;
    logic              acc_in;

    // config registers
    logic [W_W-1:0]    r_width;
    logic [H_W-1:0]    r_height;
    logic [4:0]        r_factor;
    logic              r_colour;

    // position counters
    logic [W_W-1:0]    r_col;
    logic [W_W-1:0]    r_cbase;   // first column of current tile
    logic [ADDR_W-1:0] r_tcol;
    logic [3:0]        r_cit;
    logic [H_W-1:0]    r_row;
    logic [H_W-1:0]    r_rbase;
    logic [3:0]        r_rit;

    logic              col_fit;
    logic              row_fit;
    logic              col_lastt;
    logic              row_lastt;
    logic              cfg_ok;
    ibd_pkg::t_acc_req req;
    ibd_pkg::t_sum     sum;
    logic              sum_vld;
    logic [3:0]        w_idx;

    assign adv         = !(o_out_valid && i_out_stall);
    assign o_in_stall  = !adv;
    assign o_cfg_ready = 1'b1;
    assign acc_in      = i_in_valid && adv;

    // tile fits when its last column/row lies inside the image
    assign col_fit   = (W_W + 1)'(r_cbase) + (W_W + 1)'(r_factor) <= (W_W + 1)'(r_width);
    assign row_fit   = (H_W + 1)'(r_rbase) + (H_W + 1)'(r_factor) <= (H_W + 1)'(r_height);
    assign col_lastt = (W_W + 2)'(r_cbase) + (W_W + 2)'({r_factor, 1'b0})
                       > (W_W + 2)'(r_width);
    assign row_lastt = (H_W + 2)'(r_rbase) + (H_W + 2)'({r_factor, 1'b0})
                       > (H_W + 2)'(r_height);

    assign w_idx = 4'(r_rit * 4'd3) + r_cit;

    always_comb begin
        req.wr     = col_fit && row_fit;
        req.first  = (r_cit == 4'd0) && (r_rit == 4'd0);
        req.weight = (r_factor == 5'd3) ? ibd_pkg::WEIGHTS3[w_idx] : 3'd1;
        req.red    = i_red;
        req.green  = r_colour ? i_green : 8'd0;
        req.blue   = r_colour ? i_blue  : 8'd0;
        req.done   = (5'(r_cit) + 5'd1 == r_factor) && (5'(r_rit) + 5'd1 == r_factor);
        req.last   = col_lastt && row_lastt;
        req.recip  = ibd_pkg::recip_of(r_factor);
    end

    always_comb begin
        case (i_cfg_index)
            ibd_pkg::REG_WIDTH:
                cfg_ok = i_cfg_data >= 16'd1 && 17'(i_cfg_data) <= 17'(MAX_WIDTH);
            ibd_pkg::REG_HEIGHT:
                cfg_ok = i_cfg_data >= 16'd1 && i_cfg_data <= 16'd4096;
            ibd_pkg::REG_FACTOR:
                cfg_ok = i_cfg_data >= 16'd2 && i_cfg_data <= 16'(ibd_pkg::MAX_FACTOR)
                         && (i_cfg_data == 16'd3 || !i_cfg_data[0]);
            ibd_pkg::REG_COLOUR:
                cfg_ok = 1'b1;
            default:
                cfg_ok = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= W_W'(W_RESET);
            r_height <= H_W'(4096);
            r_factor <= 5'd2;
            r_colour <= 1'b1;
            r_col    <= '0;
            r_cbase  <= '0;
            r_tcol   <= '0;
            r_cit    <= '0;
            r_row    <= '0;
            r_rbase  <= '0;
            r_rit    <= '0;
        end else if (i_cfg_valid && cfg_ok) begin
            case (i_cfg_index)
                ibd_pkg::REG_WIDTH:  r_width  <= W_W'(i_cfg_data);
                ibd_pkg::REG_HEIGHT: r_height <= H_W'(i_cfg_data);
                ibd_pkg::REG_FACTOR: r_factor <= 5'(i_cfg_data);
                default:             r_colour <= i_cfg_data[0];
            endcase
            // any accepted write restarts the frame
            r_col   <= '0;
            r_cbase <= '0;
            r_tcol  <= '0;
            r_cit   <= '0;
            r_row   <= '0;
            r_rbase <= '0;
            r_rit   <= '0;
        end else if (acc_in) begin
            if (r_col + W_W'(1) == r_width) begin
                // end of line
                r_col   <= '0;
                r_cbase <= '0;
                r_tcol  <= '0;
                r_cit   <= '0;
                if (r_row + H_W'(1) == r_height) begin
                    r_row   <= '0;
                    r_rbase <= '0;
                    r_rit   <= '0;
                end else begin
                    r_row <= r_row + H_W'(1);
                    if (5'(r_rit) + 5'd1 == r_factor) begin
                        r_rit   <= '0;
                        r_rbase <= r_rbase + H_W'(r_factor);
                    end else begin
                        r_rit <= r_rit + 4'd1;
                    end
                end
            end else begin
                r_col <= r_col + W_W'(1);
                if (5'(r_cit) + 5'd1 == r_factor) begin
                    r_cit   <= '0;
                    r_cbase <= r_cbase + W_W'(r_factor);
                    r_tcol  <= r_tcol + ADDR_W'(1);
                end else begin
                    r_cit <= r_cit + 4'd1;
                end
            end
        end
    end

    ibd_accum #(
        .ADDR_W (ADDR_W)
    ) u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_req_vld (i_in_valid),
        .i_addr    (r_tcol),
        .i_req     (req),
        .o_sum     (sum),
        .o_sum_vld (sum_vld)
    );

    ibd_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_sum_vld   (sum_vld),
        .i_sum       (sum),
        .o_out_valid (o_out_valid),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_out_last  (o_out_last)
    );
endmodule
`default_nettype wire
